[rtl/nchw_to_nhwc_transpose_top_macros.svh]
`ifndef NCHW_TO_NHWC_TRANSPOSE_TOP_MACROS_SVH
`define NCHW_TO_NHWC_TRANSPOSE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nchw_nhwc_pkg.sv]
`timescale 1ns / 1ps
package nchw_nhwc_pkg;

    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int ELEMENT_BITS_DEF = 32;
    localparam int DIM_W            = 13;
    localparam int CNT_W            = 12;
    localparam int DATA_W           = 32;
    localparam int CFG_IDX_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BATCH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 8'd3;

    typedef enum logic [1:0] {
        ST_LOADED    = 2'd0,
        ST_DATA      = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_SHAPE     = 2'd3
    } t_status;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_FETCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_HW,
        SQ_CHW,
        SQ_TOT
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic bad;
    } t_shape_stat;

endpackage

[rtl/nchw_to_nhwc_transpose_top.sv]
`timescale 1ns / 1ps
// Channel   Signals                                          Direction
// request   start, busy, i_command, i_element_value          in (start), out (busy)
// result    o_result_strobe, o_status, o_data_out, o_last_out out, one cycle each
// config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data in, ready always high
//
// One request per cycle while busy is low; its result shows in the cycle after acceptance,
// as the element buffer has a registered read port.
// busy is high while i_cfg_valid is high, and after reset or after a write to a dimension
// register while the shape product unit recomputes in its HW, CHW and TOT states.
// Synchronous active-low reset; the buffer is not cleared and needs no clearing pass.
// The receiver cannot stall; results are never held.
`include "nchw_to_nhwc_transpose_top_macros.svh"
module nchw_to_nhwc_transpose_top #(
    parameter int MAX_ELEMENTS = nchw_nhwc_pkg::MAX_ELEMENTS_DEF,
    parameter int ELEMENT_BITS = nchw_nhwc_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [nchw_nhwc_pkg::DATA_W-1:0]    i_element_value,
    output logic                                o_result_strobe,
    output logic [1:0]                          o_status,
    output logic [nchw_nhwc_pkg::DATA_W-1:0]    o_data_out,
    output logic                                o_last_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nchw_nhwc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nchw_nhwc_pkg::DIM_W-1:0]     i_cfg_data
);
    import nchw_nhwc_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int TW = $clog2(MAX_ELEMENTS+1) + 1;

    logic [DIM_W-1:0]        r_dim_batch, n_dim_batch;
    logic [DIM_W-1:0]        r_dim_channel, n_dim_channel;
    logic [DIM_W-1:0]        r_dim_height, n_dim_height;
    logic [DIM_W-1:0]        r_dim_width, n_dim_width;
    logic [TW-1:0]           r_load_count, n_load_count;
    logic [CNT_W-1:0]        r_fc, n_fc;
    logic [CNT_W-1:0]        r_fw, n_fw;
    logic [CNT_W-1:0]        r_fh, n_fh;
    logic [CNT_W-1:0]        r_fn, n_fn;
    logic [AW-1:0]           r_src, n_src;
    logic [AW-1:0]           r_row, n_row;
    logic [AW-1:0]           r_bbase, n_bbase;
    logic                    r_ready, n_ready;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic                    r_out_last, n_out_last;
    logic                    r_out_sel, n_out_sel;

    t_shape_stat             w_stat;
    logic [TW-1:0]           w_hw, w_chw, w_total;
    logic                    w_cfg_wr, w_cfg_known, w_accept;
    logic                    w_we, w_re;
    logic [ELEMENT_BITS-1:0] w_rdata;
    logic                    w_c_wrap, w_w_wrap, w_h_wrap, w_n_wrap;
    logic [AW-1:0]           w_row_inc, w_bb_inc, w_src_inc;

    nchw_nhwc_shape #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_shape (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_cfg_wr && w_cfg_known),
        .i_dim_batch  (r_dim_batch),
        .i_dim_channel(r_dim_channel),
        .i_dim_height (r_dim_height),
        .i_dim_width  (r_dim_width),
        .o_stat       (w_stat),
        .o_hw         (w_hw),
        .o_chw        (w_chw),
        .o_total      (w_total)
    );

    nchw_nhwc_buf #(
        .DEPTH(MAX_ELEMENTS),
        .WIDTH(ELEMENT_BITS)
    ) u_buf (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_load_count[AW-1:0]),
        .i_wdata(ELEMENT_BITS'(i_element_value)),
        .i_re   (w_re),
        .i_raddr(r_src),
        .o_rdata(w_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign busy        = w_stat.busy || i_cfg_valid;
    assign w_accept    = start && !busy;

    assign w_c_wrap  = ({1'b0, r_fc} + DIM_W'(1)) == r_dim_channel;
    assign w_w_wrap  = ({1'b0, r_fw} + DIM_W'(1)) == r_dim_width;
    assign w_h_wrap  = ({1'b0, r_fh} + DIM_W'(1)) == r_dim_height;
    assign w_n_wrap  = ({1'b0, r_fn} + DIM_W'(1)) == r_dim_batch;
    assign w_src_inc = AW'(TW'(r_src) + w_hw);
    assign w_row_inc = r_row + AW'(1);
    assign w_bb_inc  = AW'(TW'(r_bbase) + w_chw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_batch   <= DIM_W'(1);
            r_dim_channel <= DIM_W'(1);
            r_dim_height  <= DIM_W'(1);
            r_dim_width   <= DIM_W'(1);
            r_load_count  <= '0;
            r_fc          <= '0;
            r_fw          <= '0;
            r_fh          <= '0;
            r_fn          <= '0;
            r_src         <= '0;
            r_row         <= '0;
            r_bbase       <= '0;
            r_ready       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_dim_batch   <= n_dim_batch;
            r_dim_channel <= n_dim_channel;
            r_dim_height  <= n_dim_height;
            r_dim_width   <= n_dim_width;
            r_load_count  <= n_load_count;
            r_fc          <= n_fc;
            r_fw          <= n_fw;
            r_fh          <= n_fh;
            r_fn          <= n_fn;
            r_src         <= n_src;
            r_row         <= n_row;
            r_bbase       <= n_bbase;
            r_ready       <= n_ready;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_sel    <= n_out_sel;
    end

    always_comb begin
        n_dim_batch   = r_dim_batch;
        n_dim_channel = r_dim_channel;
        n_dim_height  = r_dim_height;
        n_dim_width   = r_dim_width;
        n_load_count  = r_load_count;
        n_fc          = r_fc;
        n_fw          = r_fw;
        n_fh          = r_fh;
        n_fn          = r_fn;
        n_src         = r_src;
        n_row         = r_row;
        n_bbase       = r_bbase;
        n_ready       = r_ready;
        n_out_valid   = w_accept;
        n_out_status  = r_out_status;
        n_out_last    = 1'b0;
        n_out_sel     = 1'b0;
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_cfg_known   = 1'b1;

        case (i_cfg_index)
            REG_BATCH:   if (w_cfg_wr) n_dim_batch   = i_cfg_data;
            REG_CHANNEL: if (w_cfg_wr) n_dim_channel = i_cfg_data;
            REG_HEIGHT:  if (w_cfg_wr) n_dim_height  = i_cfg_data;
            REG_WIDTH:   if (w_cfg_wr) n_dim_width   = i_cfg_data;
            default:     w_cfg_known = 1'b0;
        endcase

        if (w_cfg_wr && w_cfg_known) begin
            n_load_count = '0;
            n_fc         = '0;
            n_fw         = '0;
            n_fh         = '0;
            n_fn         = '0;
            n_src        = '0;
            n_row        = '0;
            n_bbase      = '0;
            n_ready      = 1'b0;
        end else if (w_accept) begin
            if (w_stat.bad) begin
                n_out_status = ST_SHAPE;
            end else if (i_command == CMD_LOAD) begin
                if (r_ready) begin
                    n_out_status = ST_NOT_READY;
                end else begin
                    w_we         = 1'b1;
                    n_load_count = r_load_count + TW'(1);
                    n_ready      = (n_load_count == w_total);
                    n_out_status = ST_LOADED;
                end
            end else if (!r_ready) begin
                n_out_status = ST_NOT_READY;
            end else begin
                w_re         = 1'b1;
                n_out_status = ST_DATA;
                n_out_sel    = 1'b1;
                if (!w_c_wrap) begin
                    n_fc  = r_fc + CNT_W'(1);
                    n_src = w_src_inc;
                end else begin
                    n_fc = '0;
                    if (!w_w_wrap) begin
                        n_fw  = r_fw + CNT_W'(1);
                        n_row = w_row_inc;
                        n_src = w_row_inc;
                    end else if (!w_h_wrap) begin
                        n_fw  = '0;
                        n_fh  = r_fh + CNT_W'(1);
                        n_row = w_row_inc;
                        n_src = w_row_inc;
                    end else if (!w_n_wrap) begin
                        n_fw    = '0;
                        n_fh    = '0;
                        n_fn    = r_fn + CNT_W'(1);
                        n_bbase = w_bb_inc;
                        n_row   = w_bb_inc;
                        n_src   = w_bb_inc;
                    end else begin
                        // final element: drop the tensor
                        n_out_last   = 1'b1;
                        n_load_count = '0;
                        n_fw         = '0;
                        n_fh         = '0;
                        n_fn         = '0;
                        n_src        = '0;
                        n_row        = '0;
                        n_bbase      = '0;
                        n_ready      = 1'b0;
                    end
                end
            end
        end
    end

    assign o_result_strobe = r_out_valid;
    assign o_status        = r_out_status;
    assign o_last_out      = r_out_last;
    assign o_data_out      = r_out_sel ? DATA_W'(w_rdata) : '0;

    `NN_ASSERT_NEXT(a_result_follows, w_accept, o_result_strobe, "request without result")
    `NN_ASSERT_NEXT(a_no_spurious, !w_accept, !o_result_strobe, "result without request")
    `NN_ASSERT_NOW(a_last_is_data, o_result_strobe && o_last_out, o_status == ST_DATA,
                   "last on non-data result")
    `NN_ASSERT_NOW(a_ready_full, r_ready && !w_stat.busy, r_load_count == w_total,
                   "ready with partial tensor")

endmodule

[rtl/nchw_nhwc_buf.sv]
`timescale 1ns / 1ps
module nchw_nhwc_buf #(
    parameter int DEPTH = nchw_nhwc_pkg::MAX_ELEMENTS_DEF,
    parameter int WIDTH = nchw_nhwc_pkg::ELEMENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/nchw_nhwc_shape.sv]
`timescale 1ns / 1ps
module nchw_nhwc_shape #(
    parameter int MAX_ELEMENTS = nchw_nhwc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_restart,
    input  logic [nchw_nhwc_pkg::DIM_W-1:0]        i_dim_batch,
    input  logic [nchw_nhwc_pkg::DIM_W-1:0]        i_dim_channel,
    input  logic [nchw_nhwc_pkg::DIM_W-1:0]        i_dim_height,
    input  logic [nchw_nhwc_pkg::DIM_W-1:0]        i_dim_width,
    output nchw_nhwc_pkg::t_shape_stat             o_stat,
    output logic [$clog2(MAX_ELEMENTS+1):0]        o_hw,
    output logic [$clog2(MAX_ELEMENTS+1):0]        o_chw,
    output logic [$clog2(MAX_ELEMENTS+1):0]        o_total
);
    import nchw_nhwc_pkg::*;

    localparam int TW = $clog2(MAX_ELEMENTS+1) + 1;
    localparam int PW = TW + DIM_W;

    t_seq_state     r_state, n_state;
    logic [TW-1:0]  r_hw, n_hw;
    logic [TW-1:0]  r_chw, n_chw;
    logic [TW-1:0]  r_total, n_total;
    logic           r_bad, n_bad;
    logic [DIM_W-1:0] w_mul_a;
    logic [TW-1:0]  w_mul_b;
    logic [PW-1:0]  w_prod;
    logic           w_over;
    logic [TW-1:0]  w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_HW;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hw    <= n_hw;
        r_chw   <= n_chw;
        r_total <= n_total;
    end

    assign w_prod = PW'(w_mul_a) * PW'(w_mul_b);
    assign w_over = w_prod > PW'(MAX_ELEMENTS);
    assign w_sat  = w_over ? TW'(MAX_ELEMENTS + 1) : w_prod[TW-1:0];

    always_comb begin
        n_state = r_state;
        n_hw    = r_hw;
        n_chw   = r_chw;
        n_total = r_total;
        n_bad   = r_bad;
        w_mul_a = i_dim_height;
        w_mul_b = TW'(i_dim_width);
        case (r_state)
            SQ_IDLE: begin
                n_state = SQ_IDLE;
            end
            SQ_HW: begin
                n_hw    = w_sat;
                n_state = SQ_CHW;
            end
            SQ_CHW: begin
                w_mul_a = i_dim_channel;
                w_mul_b = r_hw;
                n_chw   = w_sat;
                n_state = SQ_TOT;
            end
            SQ_TOT: begin
                w_mul_a = i_dim_batch;
                w_mul_b = r_chw;
                n_total = w_sat;
                n_bad   = w_over || (w_prod == '0);
                n_state = SQ_IDLE;
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
        if (i_restart) begin
            n_state = SQ_HW;
        end
    end

    assign o_stat.busy = (r_state != SQ_IDLE);
    assign o_stat.bad  = r_bad;
    assign o_hw        = r_hw;
    assign o_chw       = r_chw;
    assign o_total     = r_total;

endmodule

[sim/nchw_to_nhwc_transpose_top_test.sv]
`timescale 1ns / 1ps
module nchw_to_nhwc_transpose_top_test;
    import nchw_nhwc_pkg::*;

    localparam int BUF_DEPTH   = MAX_ELEMENTS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;
    localparam logic [DIM_W-1:0]     DIM_ALL_ONES   = 13'h1FFF;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_reply;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [DATA_W-1:0]    i_element_value;
    logic                 o_result_strobe;
    logic [1:0]           o_status;
    logic [DATA_W-1:0]    o_data_out;
    logic                 o_last_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    logic [DIM_W-1:0]  dim_n, dim_c, dim_h, dim_w;
    logic [DIM_W-1:0]  loaded, pos_n, pos_c, pos_h, pos_w;
    logic              tensor_full;
    logic [DATA_W-1:0] element_store [BUF_DEPTH];
    t_reply            nhwc_replies [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int useful_items   = 0;
    bit gaps_on        = 1'b1;

    nchw_to_nhwc_transpose_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_element_value (i_element_value),
        .o_result_strobe (o_result_strobe),
        .o_status        (o_status),
        .o_data_out      (o_data_out),
        .o_last_out      (o_last_out),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nchw_to_nhwc_transpose_top test failed");
            $finish;
        end
    end

    function automatic void clear_progress();
        loaded      = '0;
        pos_n       = '0;
        pos_c       = '0;
        pos_h       = '0;
        pos_w       = '0;
        tensor_full = 1'b0;
    endfunction

    function automatic t_reply transpose_step(t_cmd cmd, logic [DATA_W-1:0] value);
        t_reply            r;
        longint unsigned   total;
        longint unsigned   src;
        r.status = ST_SHAPE;
        r.data   = '0;
        r.last   = 1'b0;
        total = dim_n;
        total = total * dim_c;
        total = total * dim_h;
        total = total * dim_w;
        if (total == 0 || total > BUF_DEPTH) begin
            return r;
        end
        if (cmd == CMD_LOAD) begin
            if (tensor_full || loaded >= total) begin
                r.status = ST_NOT_READY;
                return r;
            end
            element_store[loaded] = value;
            loaded = loaded + 1'b1;
            if (loaded == total) begin
                tensor_full = 1'b1;
            end
            r.status = ST_LOADED;
            return r;
        end
        if (!tensor_full) begin
            r.status = ST_NOT_READY;
            return r;
        end
        src = ((64'(pos_n) * dim_c + pos_c) * dim_h + pos_h) * dim_w + pos_w;
        r.data   = (src < BUF_DEPTH) ? element_store[src] : '0;
        r.status = ST_DATA;
        pos_c = pos_c + 1'b1;
        if (pos_c >= dim_c) begin
            pos_c = '0;
            pos_w = pos_w + 1'b1;
            if (pos_w >= dim_w) begin
                pos_w = '0;
                pos_h = pos_h + 1'b1;
                if (pos_h >= dim_h) begin
                    pos_h = '0;
                    pos_n = pos_n + 1'b1;
                    if (pos_n >= dim_n) begin
                        r.last = 1'b1;
                        clear_progress();
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n && o_result_strobe) begin
            if (nhwc_replies.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected reply: status %0d data %h last %0d",
                             o_status, o_data_out, o_last_out);
                end
                mismatch_count++;
            end else begin
                want = nhwc_replies.pop_front();
                if (o_status !== want.status || o_data_out !== want.data ||
                    o_last_out !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display("reply mismatch: status %0d/%0d data %h/%h last %0d/%0d",
                                 want.status, o_status, want.data, o_data_out,
                                 want.last, o_last_out);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(t_cmd cmd, logic [DATA_W-1:0] value);
        t_reply r;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_element_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = transpose_step(cmd, value);
        nhwc_replies.insert(nhwc_replies.size(), r);
        if (r.status == ST_LOADED || r.status == ST_DATA) begin
            useful_items++;
        end
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (nhwc_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        drain_replies();
        while (busy) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_BATCH:   dim_n = value;
            REG_CHANNEL: dim_c = value;
            REG_HEIGHT:  dim_h = value;
            REG_WIDTH:   dim_w = value;
            default:     ;
        endcase
        if (idx <= REG_WIDTH) begin
            clear_progress();
        end
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_shape(logic [DIM_W-1:0] n, logic [DIM_W-1:0] c,
                             logic [DIM_W-1:0] h, logic [DIM_W-1:0] w);
        write_register(REG_BATCH, n);
        write_register(REG_CHANNEL, c);
        write_register(REG_HEIGHT, h);
        write_register(REG_WIDTH, w);
    endtask

    task automatic stream_tensor(t_cmd cmd, int count);
        for (int i = 0; i < count; i++) begin
            send_request(cmd, $urandom);
        end
    endtask

    task automatic test_reset_shape();
        send_request(CMD_FETCH, 32'hFFFF_FFFF);
        send_request(CMD_LOAD, 32'h0000_0000);
        send_request(CMD_LOAD, 32'hFFFF_FFFF);
        send_request(CMD_FETCH, 32'h0000_0000);
        send_request(CMD_FETCH, 32'h0000_0000);
    endtask

    task automatic test_small_transpose();
        logic [DATA_W-1:0] vals [8];
        vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};
        set_shape(13'd1, 13'd2, 13'd2, 13'd2);
        for (int i = 0; i < 8; i++) begin
            if (i == 3) begin
                send_request(CMD_FETCH, 32'hFFFF_FFFF);
            end
            send_request(CMD_LOAD, vals[i]);
        end
        send_request(CMD_LOAD, 32'hDEAD_BEEF);
        stream_tensor(CMD_FETCH, 8);
    endtask

    task automatic test_shape_errors();
        set_shape(13'd2, 13'd2, 13'd2, 13'd0);
        send_request(CMD_LOAD, $urandom);
        send_request(CMD_FETCH, $urandom);
        write_register(REG_UNUSED_TOP, DIM_ALL_ONES);
        set_shape(DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES, DIM_ALL_ONES);
        send_request(CMD_LOAD, $urandom);
        send_request(CMD_FETCH, $urandom);
        set_shape(13'd4097, 13'd1, 13'd1, 13'd1);
        send_request(CMD_LOAD, $urandom);
        send_request(CMD_FETCH, $urandom);
    endtask

    task automatic test_restart();
        set_shape(13'd1, 13'd1, 13'd2, 13'd2);
        stream_tensor(CMD_LOAD, 2);
        write_register(REG_UNUSED_TOP, '0);
        stream_tensor(CMD_LOAD, 2);
        write_register(REG_HEIGHT, 13'd2);
        send_request(CMD_FETCH, $urandom);
        stream_tensor(CMD_LOAD, 4);
        stream_tensor(CMD_FETCH, 4);
    endtask

    task automatic test_full_buffer();
        set_shape(13'd1, 13'd4096, 13'd1, 13'd1);
        stream_tensor(CMD_LOAD, 8);
        send_request(CMD_FETCH, $urandom);
        set_shape(13'd4096, 13'd1, 13'd1, 13'd1);
        stream_tensor(CMD_LOAD, 8);
        send_request(CMD_FETCH, $urandom);
        set_shape(13'd1, 13'd16, 13'd16, 13'd16);
        stream_tensor(CMD_LOAD, 8);
        send_request(CMD_FETCH, $urandom);
    endtask

    task automatic test_random_tensors();
        logic [DIM_W-1:0]     shp [4];
        logic [CFG_IDX_W-1:0] idx;
        int                   total;
        int                   i;
        useful_items = 0;
        while (useful_items < 1000) begin
            gaps_on = (useful_items < 850) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k < 4; k++) begin
                    shp[k] = DIM_W'($urandom_range(9, DIM_ALL_ONES));
                end
                if ($urandom_range(0, 1)) begin
                    shp[$urandom_range(0, 3)] = '0;
                end
                set_shape(shp[REG_BATCH], shp[REG_CHANNEL], shp[REG_HEIGHT], shp[REG_WIDTH]);
                repeat ($urandom_range(2, 5)) send_request(t_cmd'($urandom_range(0, 1)), $urandom);
                continue;
            end
            shp[REG_BATCH]   = DIM_W'($urandom_range(1, 2));
            shp[REG_CHANNEL] = DIM_W'($urandom_range(1, 4));
            shp[REG_HEIGHT]  = DIM_W'($urandom_range(1, 4));
            shp[REG_WIDTH]   = DIM_W'($urandom_range(1, 4));
            set_shape(shp[REG_BATCH], shp[REG_CHANNEL], shp[REG_HEIGHT], shp[REG_WIDTH]);
            total = int'(shp[REG_BATCH]) * int'(shp[REG_CHANNEL]) *
                    int'(shp[REG_HEIGHT]) * int'(shp[REG_WIDTH]);
            i = 0;
            while (i < total) begin
                if ($urandom_range(0, 49) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        idx = CFG_IDX_W'($urandom_range(REG_BATCH, REG_WIDTH));
                        write_register(idx, shp[idx]);
                        i = 0;
                    end else begin
                        write_register(CFG_IDX_W'($urandom_range(REG_WIDTH + 1, REG_UNUSED_TOP)),
                                       DIM_W'($urandom));
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    send_request(CMD_FETCH, $urandom);
                end
                send_request(CMD_LOAD, $urandom);
                i++;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_request(CMD_LOAD, $urandom);
            end
            for (int j = 0; j < total; j++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_request(CMD_LOAD, $urandom);
                end
                if (j > 0 && $urandom_range(0, 199) == 0) begin
                    break;
                end
                send_request(CMD_FETCH, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= CMD_LOAD;
        i_element_value <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_BATCH;
        i_cfg_data      <= '0;
        dim_n = 13'd1;
        dim_c = 13'd1;
        dim_h = 13'd1;
        dim_w = 13'd1;
        clear_progress();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_shape();
        test_small_transpose();
        test_shape_errors();
        test_restart();
        test_full_buffer();
        test_random_tensors();

        drain_replies();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && nhwc_replies.size() == 0) begin
            $display("nchw_to_nhwc_transpose_top test passed");
        end else begin
            $display("nchw_to_nhwc_transpose_top test failed");
        end
        $finish;
    end

endmodule
